@@ hdl/pfxd_pkg.sv @@
// Shared constants, codes and control/status types of the page framebuffer draw core.
package pfxd_pkg;

    localparam int COLUMNS = 128;
    localparam int ROWS    = 64;
    localparam int PAGES   = (ROWS + 7) / 8;
    localparam int WORD_W  = PAGES * 8;
    localparam int COL_AW  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

    localparam logic [2:0] ACT_CLEAR = 3'd0;
    localparam logic [2:0] ACT_PLOT  = 3'd1;
    localparam logic [2:0] ACT_HLINE = 3'd2;
    localparam logic [2:0] ACT_VLINE = 3'd3;
    localparam logic [2:0] ACT_READ  = 3'd4;

    typedef logic [2:0]        act_t;
    typedef logic [WORD_W-1:0] word_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic sweep;
        logic step;
        logic wr;
        logic cap;
        logic fin;
    } pfxd_ctl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        act_t act;
        logic cnt_zero;
        logic hit;
        logic px_ok;
        logic col_ok;
        logic len_pos;
        logic last_col;
        logic out_free;
    } pfxd_sts_t;

endpackage

@@ hdl/pfxd_if.sv @@
// Request and response channel interfaces of the page framebuffer draw core.
interface pfxd_req_if;
    import pfxd_pkg::*;
    logic        valid;
    logic        ready;
    act_t        action;
    logic [6:0]  col;
    logic [5:0]  row;
    logic signed [7:0] length;
    logic [7:0]  stipple;

    modport source (output valid, output action, output col, output row, output length,
                    output stipple, input ready);
    modport sink (input valid, input action, input col, input row, input length,
                  input stipple, output ready);
endinterface

interface pfxd_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       clipped;

    modport source (output valid, output read_data, output clipped, input ready);
    modport sink (input valid, input read_data, input clipped, output ready);
endinterface

@@ hdl/pfxd_dp.sv @@
// Datapath: command registers, column walker, frame memory and result register.
module pfxd_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pfxd_pkg::pfxd_ctl_t  ctl,
    output pfxd_pkg::pfxd_sts_t  sts,
    input  pfxd_pkg::act_t       action,
    input  logic [6:0]           col,
    input  logic [5:0]           row,
    input  logic signed [7:0]    length,
    input  logic [7:0]           stipple,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic [7:0]           read_data,
    output logic                 clipped
);
    import pfxd_pkg::*;

    // One word per column, holding every page of that column.
    word_t mem [COLUMNS];

    act_t              act_reg;
    logic [5:0]        row_reg;
    logic signed [7:0] len_reg;
    logic [7:0]        pat_reg;
    logic signed [9:0] x_reg, x_next;
    logic [7:0]        cnt_reg;
    logic              clip_reg, clip_next;
    logic [7:0]        data_reg;
    word_t             rd_word_reg;
    word_t             mask;
    word_t             wdata;
    word_t             page_word;
    logic [COL_AW-1:0] addr;
    logic              out_valid_reg;
    logic [7:0]        read_data_reg;
    logic              clipped_reg;

    logic              in_col_ok, in_row_ok;
    logic signed [9:0] in_end, x_start, vend;
    logic              x_col_ok, x_row_ok, in_range;

    // Load-time checks on the incoming beat.
    assign in_col_ok = ({2'b0, col} < 9'(COLUMNS));
    assign in_row_ok = ({3'b0, row} < 9'(ROWS));
    assign in_end    = $signed({4'b0, row}) + {{2{length[7]}}, length};
    assign x_start   = $signed({3'b0, col}) + (length[7] ? {{2{length[7]}}, length} : 10'sd0);

    always_comb
    begin
        priority case (action)
            ACT_PLOT, ACT_READ: clip_next = !(in_col_ok && in_row_ok);
            ACT_VLINE:          clip_next = (length > 8'sd0) &&
                                            (!in_col_ok || (in_end > $signed(10'(ROWS))));
            default:            clip_next = 1'b0;
        endcase
    end

    assign x_col_ok = !x_reg[9] && (x_reg < $signed(10'(COLUMNS)));
    assign x_row_ok = ({3'b0, row_reg} < 9'(ROWS));
    assign in_range = x_col_ok && x_row_ok;
    assign addr     = x_reg[COL_AW-1:0];
    assign vend     = $signed({4'b0, row_reg}) + {{2{len_reg[7]}}, len_reg};

    always_comb
    begin
        for (int j = 0; j < WORD_W; j++)
        begin
            if (act_reg == ACT_VLINE)
                mask[j] = (j >= int'(row_reg)) && ($signed(10'(j)) < vend) && (j < ROWS);
            else
                mask[j] = (j == int'(row_reg)) && (j < ROWS);
        end
    end

    assign wdata     = ctl.sweep ? '0 : (rd_word_reg ^ mask);
    assign page_word = rd_word_reg >> {row_reg[5:3], 3'b000};

    always_comb
    begin
        if (ctl.load)
            x_next = (action == ACT_CLEAR) ? 10'sd0 :
                     (action == ACT_HLINE) ? x_start : $signed({3'b0, col});
        else if (ctl.sweep || ctl.step)
            x_next = x_reg + 10'sd1;
        else
            x_next = x_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.sweep || ctl.wr)
            mem[addr] <= wdata;
        rd_word_reg <= mem[addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            x_reg <= x_next;
            if (ctl.fin)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            act_reg  <= action;
            row_reg  <= row;
            len_reg  <= length;
            pat_reg  <= stipple;
            cnt_reg  <= length[7] ? 8'(-length) : 8'(length);
            clip_reg <= clip_next;
            data_reg <= '0;
        end
        else
        begin
            if (ctl.step)
            begin
                // Rotate the pattern on every column, drawn or dropped.
                pat_reg  <= {pat_reg[0], pat_reg[7:1]};
                cnt_reg  <= cnt_reg - 8'd1;
                clip_reg <= clip_reg | (pat_reg[0] & !in_range);
            end
            if (ctl.cap)
                data_reg <= page_word[7:0];
        end
        if (ctl.fin)
        begin
            read_data_reg <= data_reg;
            clipped_reg   <= clip_reg;
        end
    end

    assign sts.act      = act_reg;
    assign sts.cnt_zero = (cnt_reg == 8'd0);
    assign sts.hit      = pat_reg[0] && in_range;
    assign sts.px_ok    = in_range;
    assign sts.col_ok   = x_col_ok;
    assign sts.len_pos  = (len_reg > 8'sd0);
    assign sts.last_col = (x_reg == $signed(10'(COLUMNS - 1)));
    assign sts.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;
    assign clipped   = clipped_reg;

endmodule

@@ hdl/pfxd_ctrl.sv @@
// Controller: sequences clear sweeps and read-modify-write passes over the frame memory.
module pfxd_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  pfxd_pkg::pfxd_sts_t  sts,
    output pfxd_pkg::pfxd_ctl_t  ctl
);
    import pfxd_pkg::*;

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_DISP = 3'd2;
    localparam logic [2:0] S_HCHK = 3'd3;
    localparam logic [2:0] S_RD   = 3'd4;
    localparam logic [2:0] S_WR   = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       clr_cmd_reg, clr_cmd_next;

    always_comb
    begin
        state_next   = state_reg;
        clr_cmd_next = clr_cmd_reg;
        ctl          = '0;
        req_ready    = 1'b0;
        unique case (state_reg)
            S_CLR:
            begin
                ctl.sweep = 1'b1;
                if (sts.last_col)
                    state_next = clr_cmd_reg ? S_FIN : S_IDLE;
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                priority case (sts.act)
                    ACT_CLEAR:
                    begin
                        clr_cmd_next = 1'b1;
                        state_next   = S_CLR;
                    end
                    ACT_PLOT, ACT_READ: state_next = sts.px_ok ? S_RD : S_FIN;
                    ACT_HLINE:          state_next = S_HCHK;
                    ACT_VLINE:          state_next = (sts.col_ok && sts.len_pos) ? S_RD : S_FIN;
                    default:            state_next = S_FIN;
                endcase
            end
            S_HCHK:
            begin
                if (sts.cnt_zero)
                    state_next = S_FIN;
                else if (sts.hit)
                    state_next = S_RD;
                else
                    ctl.step = 1'b1;
            end
            S_RD:
                state_next = S_WR;
            S_WR:
            begin
                priority case (sts.act)
                    ACT_READ:
                    begin
                        ctl.cap    = 1'b1;
                        state_next = S_FIN;
                    end
                    ACT_HLINE:
                    begin
                        ctl.wr     = 1'b1;
                        ctl.step   = 1'b1;
                        state_next = S_HCHK;
                    end
                    default:
                    begin
                        ctl.wr     = 1'b1;
                        state_next = S_FIN;
                    end
                endcase
            end
            S_FIN:
            begin
                // Hold until the result register can take the beat.
                if (sts.out_free)
                begin
                    ctl.fin      = 1'b1;
                    clr_cmd_next = 1'b0;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLR;
            clr_cmd_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cmd_reg <= clr_cmd_next;
        end
    end

endmodule

@@ hdl/page_framebuffer_xor_draw_core.sv @@
// Top level of the page framebuffer XOR draw core.
// Keeps a COLUMNS x ROWS one-bit picture in a single-port memory with one word per column
// (all pages of that column side by side) and takes one command per request beat. Every
// pixel change is a read-modify-write of one column word: plot, read byte and vertical
// line pass through dispatch, read, write and finish states, a vertical line touching all
// its rows at once through a row mask; a vertical line of no rows and an unused action
// go from dispatch straight to finish. A horizontal line steps once per pattern-zero or
// dropped column and reads and writes each drawn column. Clear sweeps the memory one
// column per cycle; the same sweep runs after reset, during which no request is
// accepted. A finished result waits in an output register, and the next request is accepted
// while it waits.
module page_framebuffer_xor_draw_core (
    input  logic      clk,
    input  logic      rst_n,
    pfxd_req_if.sink  req,
    pfxd_rsp_if.source rsp
);
    import pfxd_pkg::*;

    pfxd_ctl_t ctl;
    pfxd_sts_t sts;
    logic      req_ready;

    pfxd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    pfxd_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .sts       (sts),
        .action    (req.action),
        .col       (req.col),
        .row       (req.row),
        .length    (req.length),
        .stipple   (req.stipple),
        .out_ready (rsp.ready),
        .out_valid (rsp.valid),
        .read_data (rsp.read_data),
        .clipped   (rsp.clipped)
    );

    assign req.ready = req_ready;

endmodule

@@ tb/page_framebuffer_xor_draw_core_tb.sv @@
// Self-checking testbench of the page framebuffer XOR draw core.
module page_framebuffer_xor_draw_core_tb;
    import pfxd_pkg::*;

    localparam act_t ACT_SPARE_FIRST = 3'd5;
    localparam act_t ACT_SPARE_MID   = 3'd6;
    localparam act_t ACT_SPARE_LAST  = 3'd7;
    localparam int   RANDOM_CMDS     = 1100;
    localparam int   STALL_LIMIT     = 4000;
    localparam int   DRAIN_CYCLES    = 400;

    typedef struct {
        act_t              action;
        logic [6:0]        col;
        logic [5:0]        row;
        logic signed [7:0] length;
        logic [7:0]        stipple;
    } draw_cmd_t;

    typedef struct {
        logic [7:0] read_data;
        logic       clipped;
    } draw_result_t;

    logic clk = 1'b0;
    logic rst_n;

    pfxd_req_if req_ch ();
    pfxd_rsp_if rsp_ch ();

    page_framebuffer_xor_draw_core u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #4 clk = ~clk;

    // Expected picture: one byte per page and column, bit n is row 8*page+n.
    logic [7:0]   frame_image [PAGES][COLUMNS];
    draw_cmd_t    pending_cmds[$];
    draw_result_t expected_results[$];
    draw_cmd_t    cmd_on_bus;
    int           errors = 0;
    int           cmds_sent = 0;
    int           results_seen = 0;
    int           idle_cycles = 0;

    function automatic bit toggle_pixel(int x, int y);
        if (x < 0 || x >= COLUMNS || y < 0 || y >= ROWS)
            return 1'b1;
        frame_image[y / 8][x] ^= 8'(1 << (y % 8));
        return 1'b0;
    endfunction

    function automatic draw_result_t draw_command(draw_cmd_t c);
        draw_result_t res;
        int           x;
        int           w;
        logic [7:0]   pat;
        res.read_data = 8'h00;
        res.clipped   = 1'b0;
        case (c.action)
            ACT_CLEAR:
            begin
                for (int p = 0; p < PAGES; p++)
                    for (int k = 0; k < COLUMNS; k++)
                        frame_image[p][k] = 8'h00;
            end
            ACT_PLOT:
            begin
                res.clipped = toggle_pixel(int'(c.col), int'(c.row));
            end
            ACT_HLINE:
            begin
                x   = int'(c.col);
                w   = int'(c.length);
                pat = c.stipple;
                // Negative width runs leftward, ending just before the start column.
                if (w < 0)
                begin
                    x = x + w;
                    w = -w;
                end
                for (int i = 0; i < w; i++)
                begin
                    if (pat[0] && toggle_pixel(x + i, int'(c.row)))
                        res.clipped = 1'b1;
                    pat = {pat[0], pat[7:1]};
                end
            end
            ACT_VLINE:
            begin
                for (int i = 0; i < int'(c.length); i++)
                    if (toggle_pixel(int'(c.col), int'(c.row) + i))
                        res.clipped = 1'b1;
            end
            ACT_READ:
            begin
                if (int'(c.col) < COLUMNS && int'(c.row) < ROWS)
                    res.read_data = frame_image[c.row / 8][c.col];
                else
                    res.clipped = 1'b1;
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    task automatic add_cmd(input act_t a, input int c, input int r, input int l, input int s);
        draw_cmd_t cmd;
        cmd.action  = a;
        cmd.col     = 7'(c);
        cmd.row     = 6'(r);
        cmd.length  = 8'(l);
        cmd.stipple = 8'(s);
        pending_cmds.push_back(cmd);
    endtask

    // Request driver: gaps are drawn per beat, with windows of back-to-back traffic.
    int gap_left = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid   <= 1'b0;
            req_ch.action  <= ACT_CLEAR;
            req_ch.col     <= '0;
            req_ch.row     <= '0;
            req_ch.length  <= '0;
            req_ch.stipple <= '0;
            gap_left = 0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                expected_results.push_back(draw_command(cmd_on_bus));
                cmds_sent++;
                gap_left = ((cmds_sent / 100) % 3 == 0) ? 0 : $urandom_range(0, 15);
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (gap_left == 0 && pending_cmds.size() != 0)
                begin
                    cmd_on_bus = pending_cmds.pop_front();
                    req_ch.action  <= cmd_on_bus.action;
                    req_ch.col     <= cmd_on_bus.col;
                    req_ch.row     <= cmd_on_bus.row;
                    req_ch.length  <= cmd_on_bus.length;
                    req_ch.stipple <= cmd_on_bus.stipple;
                    req_ch.valid   <= 1'b1;
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                    if (gap_left > 0)
                        gap_left--;
                end
            end
        end
    end

    // Response monitor: compare each beat with the oldest expectation, stall at random.
    int stall_left = 0;
    always @(posedge clk or negedge rst_n)
    begin
        draw_result_t want;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result read_data %02h clipped %0b",
                             $time, rsp_ch.read_data, rsp_ch.clipped);
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (rsp_ch.read_data !== want.read_data)
                    begin
                        $display("%0t: read_data mismatch expected %02h actual %02h",
                                 $time, want.read_data, rsp_ch.read_data);
                        errors++;
                    end
                    if (rsp_ch.clipped !== want.clipped)
                    begin
                        $display("%0t: clipped mismatch expected %0b actual %0b",
                                 $time, want.clipped, rsp_ch.clipped);
                        errors++;
                    end
                end
                stall_left = ((results_seen / 70) % 3 == 1) ? 0 : $urandom_range(0, 15);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // Watchdog: end the run if no beat moves on either channel for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial
    begin
        int   pick;
        int   c;
        int   r;
        int   l;
        int   s;
        act_t a;

        rst_n          = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.action  = ACT_CLEAR;
        req_ch.col     = '0;
        req_ch.row     = '0;
        req_ch.length  = '0;
        req_ch.stipple = '0;
        rsp_ch.ready   = 1'b0;
        for (int p = 0; p < PAGES; p++)
            for (int k = 0; k < COLUMNS; k++)
                frame_image[p][k] = 8'h00;

        // Corners, extremes of length, runs off the left, right and bottom edges, stipple gaps, spare actions.
        add_cmd(ACT_READ,    0,  0,    0, 8'h00);
        add_cmd(ACT_PLOT,    0,  0,    0, 8'h00);
        add_cmd(ACT_PLOT,  127, 63,    0, 8'hff);
        add_cmd(ACT_READ,    0,  0,    0, 8'h00);
        add_cmd(ACT_READ,  127, 63,    0, 8'h00);
        add_cmd(ACT_HLINE,   0,  5,  127, 8'hff);
        add_cmd(ACT_HLINE, 127, 63, -128, 8'ha5);
        add_cmd(ACT_HLINE, 120, 10,   20, 8'h0f);
        add_cmd(ACT_HLINE, 125, 12,   10, 8'h00);
        add_cmd(ACT_HLINE,   3, 20,  -10, 8'h00);
        add_cmd(ACT_HLINE,   3, 21,  -10, 8'h80);
        add_cmd(ACT_HLINE,  50, 30,    0, 8'hff);
        add_cmd(ACT_READ,  126, 63,    0, 8'h00);
        add_cmd(ACT_READ,    0,  0,    0, 8'h00);
        add_cmd(ACT_VLINE,  64, 60,   10, 8'h00);
        add_cmd(ACT_VLINE,  65,  0,   -5, 8'h00);
        add_cmd(ACT_VLINE,  66,  0,    0, 8'h00);
        add_cmd(ACT_VLINE,   0,  0,  127, 8'h00);
        add_cmd(ACT_READ,   64, 56,    0, 8'h00);
        add_cmd(ACT_READ,    0, 40,    0, 8'h00);
        add_cmd(ACT_SPARE_FIRST, 127, 63, -1, 8'hff);
        add_cmd(ACT_SPARE_MID, 1, 1, 1, 8'h01);
        add_cmd(ACT_SPARE_LAST, 0, 0, 0, 8'h00);
        add_cmd(ACT_CLEAR,  17,  9,    0, 8'h00);
        add_cmd(ACT_READ,    0,  5,    0, 8'h00);

        // Mostly drawing and readback so the picture builds up; rare clears.
        for (int n = 0; n < RANDOM_CMDS; n++)
        begin
            pick = $urandom_range(0, 99);
            c    = $urandom_range(0, 127);
            r    = $urandom_range(0, 63);
            s    = $urandom_range(0, 255);
            if ($urandom_range(0, 7) == 0)
                l = $urandom_range(0, 255) - 128;
            else
                l = $urandom_range(0, 40) - 20;
            if (pick < 2)
                a = ACT_CLEAR;
            else if (pick < 22)
                a = ACT_PLOT;
            else if (pick < 46)
                a = ACT_HLINE;
            else if (pick < 64)
                a = ACT_VLINE;
            else if (pick < 97)
                a = ACT_READ;
            else
                a = act_t'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
            add_cmd(a, c, r, l, s);
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_cmds.size() != 0 || req_ch.valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ page_framebuffer_xor_draw_core.f @@
hdl/pfxd_pkg.sv
hdl/pfxd_if.sv
hdl/pfxd_dp.sv
hdl/pfxd_ctrl.sv
hdl/page_framebuffer_xor_draw_core.sv
tb/page_framebuffer_xor_draw_core_tb.sv
